// ===== rtl/eap_pkg.sv =====
// ----------------------------------------------------------------------------
// eap_pkg
// Shared constants and types of the eased animation progress block.
// ----------------------------------------------------------------------------
package eap_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LEVEL_W       = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int MODE_W        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START    = 3'd0,
        REG_DURATION = 3'd1,
        REG_REPEAT   = 3'd2,
        REG_CURVE    = 3'd3,
        REG_MIRROR   = 3'd4,
        REG_CONST    = 3'd5,
        REG_FROM     = 3'd6,
        REG_TO       = 3'd7
    } cfg_idx_t;

    localparam logic [MODE_W-1:0] CURVE_LINEAR = 3'd0;
    localparam logic [MODE_W-1:0] CURVE_QUAD   = 3'd1;
    localparam logic [MODE_W-1:0] CURVE_CUBIC  = 3'd2;
    localparam logic [MODE_W-1:0] CURVE_QUART  = 3'd3;
    localparam logic [MODE_W-1:0] CURVE_CONST  = 3'd4;

endpackage

// ===== rtl/eap_if.sv =====
// ----------------------------------------------------------------------------
// eap channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface eap_sample_if #(
    parameter int TIME_BITS = eap_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] now_ticks;

    modport source (output valid, output now_ticks, input ready);
    modport sink   (input valid, input now_ticks, output ready);
endinterface

interface eap_result_if #(
    parameter int FRAC_BITS = eap_pkg::FRAC_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [FRAC_BITS:0]          progress;
    logic signed [eap_pkg::LEVEL_W-1:0] level;

    modport source (output valid, output progress, output level, input ready);
    modport sink   (input valid, input progress, input level, output ready);
endinterface

interface eap_cfg_if #(
    parameter int DATA_W = eap_pkg::TIME_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [eap_pkg::CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/eap_front.sv =====
// ----------------------------------------------------------------------------
// eap_front
// Takes time samples, measures elapsed ticks and flags samples before start.
// ----------------------------------------------------------------------------
module eap_front #(
    parameter int TIME_BITS = eap_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TIME_BITS-1:0] now_ticks,
    input  logic [TIME_BITS-1:0] start_time,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic [TIME_BITS:0]   push_data
);

    logic                 valid_reg;
    logic                 before_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic                 take;

    assign push_valid = valid_reg;
    assign push_data  = {before_reg, elapsed_reg};
    assign in_ready   = !valid_reg || push_ready;
    assign take       = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (take) begin
            before_reg  <= now_ticks < start_time;
            elapsed_reg <= now_ticks - start_time;
        end
    end

endmodule

// ===== rtl/eap_queue.sv =====
// ----------------------------------------------------------------------------
// eap_queue
// Two-entry queue between the front and the evaluation pipeline.
// ----------------------------------------------------------------------------
module eap_queue #(
    parameter int W = eap_pkg::TIME_BITS_DEF + 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/eap_back.sv =====
// ----------------------------------------------------------------------------
// eap_back
// Evaluation pipeline: wrap, phase division, easing curve and interpolation.
// ----------------------------------------------------------------------------
module eap_back #(
    parameter int TIME_BITS = eap_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = eap_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [TIME_BITS:0]                 in_data,
    input  logic [TIME_BITS-1:0]               duration,
    input  logic                               repeat_en,
    input  logic [eap_pkg::MODE_W-1:0]         mode,
    input  logic                               mirror_en,
    input  logic [FRAC_BITS:0]                 const_level,
    input  logic signed [eap_pkg::LEVEL_W-1:0] from_value,
    input  logic signed [eap_pkg::LEVEL_W-1:0] to_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [FRAC_BITS:0]                 progress,
    output logic signed [eap_pkg::LEVEL_W-1:0] level
);

    localparam int T     = TIME_BITS;
    localparam int P     = FRAC_BITS + 1;
    localparam int PW    = FRAC_BITS + 2;
    localparam int LW    = eap_pkg::LEVEL_W;
    localparam int PRODW = LW + 1 + PW;
    localparam logic [P:0]   ONE_P  = (P+1)'(1) << P;
    localparam logic [P:0]   HALF_P = (P+1)'(1) << (P - 1);
    localparam logic [P+3:0] ONE_PG = (P+4)'(1) << P;
    localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic         en;
    logic [T-1:0] d;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign d        = (duration == '0) ? T'(1) : duration;

    // ---- modulo stages: one remainder bit per stage
    logic         mv_reg [T];
    logic         mb_reg [T];
    logic [T-1:0] me_reg [T];
    logic [T-1:0] mr_reg [T];

    for (genvar j = 0; j < T; j++) begin : g_mod
        logic         v_prev;
        logic         b_prev;
        logic [T-1:0] e_prev;
        logic [T-1:0] r_prev;
        logic [T:0]   t;
        logic [T-1:0] r_next;

        if (j == 0) begin : g_first
            assign v_prev = in_valid;
            assign b_prev = in_data[T];
            assign e_prev = in_data[T-1:0];
            assign r_prev = '0;
        end
        else begin : g_rest
            assign v_prev = mv_reg[j-1];
            assign b_prev = mb_reg[j-1];
            assign e_prev = me_reg[j-1];
            assign r_prev = mr_reg[j-1];
        end

        always_comb begin
            t      = {r_prev, e_prev[T-1-j]};
            r_next = (t >= {1'b0, d}) ? T'(t - {1'b0, d}) : t[T-1:0];
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                mv_reg[j] <= 1'b0;
            end
            else if (en) begin
                mv_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                mb_reg[j] <= b_prev;
                me_reg[j] <= e_prev;
                mr_reg[j] <= r_next;
            end
        end
    end

    // ---- phase stages: one quotient bit per stage
    logic         pv_reg [P];
    logic         pb_reg [P];
    logic         pe_reg [P];
    logic         pf_reg [P];
    logic [T-1:0] pr_reg [P];
    logic [P-1:0] pq_reg [P];
    logic [T-1:0] e2;

    assign e2 = repeat_en ? mr_reg[T-1] : me_reg[T-1];

    for (genvar k = 0; k < P; k++) begin : g_div
        logic         v_prev;
        logic         b_prev;
        logic         past_prev;
        logic         full_prev;
        logic [T-1:0] r_prev;
        logic [P-1:0] q_prev;
        logic [T:0]   t;
        logic         ge;
        logic [T-1:0] r_next;

        if (k == 0) begin : g_first
            assign v_prev    = mv_reg[T-1];
            assign b_prev    = mb_reg[T-1];
            assign past_prev = e2 > d;
            assign full_prev = e2 >= d;
            assign r_prev    = e2;
            assign q_prev    = '0;
        end
        else begin : g_rest
            assign v_prev    = pv_reg[k-1];
            assign b_prev    = pb_reg[k-1];
            assign past_prev = pe_reg[k-1];
            assign full_prev = pf_reg[k-1];
            assign r_prev    = pr_reg[k-1];
            assign q_prev    = pq_reg[k-1];
        end

        always_comb begin
            t      = {r_prev, 1'b0};
            ge     = t >= {1'b0, d};
            r_next = ge ? T'(t - {1'b0, d}) : t[T-1:0];
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                pv_reg[k] <= 1'b0;
            end
            else if (en) begin
                pv_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                pb_reg[k] <= b_prev;
                pe_reg[k] <= past_prev;
                pf_reg[k] <= full_prev;
                pr_reg[k] <= r_next;
                pq_reg[k] <= {q_prev[P-2:0], ge};
            end
        end
    end

    // ---- mirror and fold
    logic         cv_reg;
    logic         cb_reg;
    logic         ce_reg;
    logic         cinv_reg;
    logic [P:0]   cu_reg;
    logic [P-1:0] cvv_reg;
    logic [P:0]   x;
    logic [P:0]   u;
    logic         inv;
    logic [P:0]   v_full;

    always_comb begin
        x   = pf_reg[P-1] ? ONE_P : {1'b0, pq_reg[P-1]};
        inv = 1'b0;
        u   = x;
        if (mirror_en) begin
            if (x > HALF_P) begin
                u   = (P+1)'({x, 1'b0} - {1'b0, ONE_P});
                inv = 1'b1;
            end
            else begin
                u = (P+1)'({x, 1'b0});
            end
        end
        v_full = (u < ONE_P - u) ? u : ONE_P - u;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cv_reg <= 1'b0;
        end
        else if (en) begin
            cv_reg <= pv_reg[P-1];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            cb_reg   <= pb_reg[P-1];
            ce_reg   <= pe_reg[P-1];
            cinv_reg <= inv;
            cu_reg   <= u;
            cvv_reg  <= v_full[P-1:0];
        end
    end

    // ---- power stages: one multiply each
    logic         wv_reg [3];
    logic         wb_reg [3];
    logic         we_reg [3];
    logic         winv_reg [3];
    logic [P:0]   wu_reg [3];
    logic [P-1:0] wv2_reg [3];
    logic [P-1:0] wa_reg [3];

    for (genvar m = 0; m < 3; m++) begin : g_pow
        logic         v_prev;
        logic         b_prev;
        logic         e_prev;
        logic         inv_prev;
        logic [P:0]   u_prev;
        logic [P-1:0] vv_prev;
        logic [P-1:0] a_prev;
        logic [2*P-1:0] prod;
        logic [P-1:0] a_next;

        if (m == 0) begin : g_first
            assign v_prev   = cv_reg;
            assign b_prev   = cb_reg;
            assign e_prev   = ce_reg;
            assign inv_prev = cinv_reg;
            assign u_prev   = cu_reg;
            assign vv_prev  = cvv_reg;
            assign a_prev   = cvv_reg;
        end
        else begin : g_rest
            assign v_prev   = wv_reg[m-1];
            assign b_prev   = wb_reg[m-1];
            assign e_prev   = we_reg[m-1];
            assign inv_prev = winv_reg[m-1];
            assign u_prev   = wu_reg[m-1];
            assign vv_prev  = wv2_reg[m-1];
            assign a_prev   = wa_reg[m-1];
        end

        always_comb begin
            prod   = a_prev * vv_prev;
            a_next = a_prev;
            if (mode > eap_pkg::MODE_W'(m) && mode <= eap_pkg::CURVE_QUART) begin
                a_next = prod[2*P-1:P];
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                wv_reg[m] <= 1'b0;
            end
            else if (en) begin
                wv_reg[m] <= v_prev;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                wb_reg[m]   <= b_prev;
                we_reg[m]   <= e_prev;
                winv_reg[m] <= inv_prev;
                wu_reg[m]   <= u_prev;
                wv2_reg[m]  <= vv_prev;
                wa_reg[m]   <= a_next;
            end
        end
    end

    // ---- curve select and rounding to progress
    logic                 fv_reg;
    logic [FRAC_BITS:0]   fp_reg;
    logic [P+3:0]         g;
    logic [P:0]           cur;
    logic [P:0]           r;
    logic [P:0]           p_round;
    logic [FRAC_BITS:0]   p_next;
    logic [FRAC_BITS:0]   c_clamp;

    always_comb begin
        c_clamp = (const_level > ONE_F) ? ONE_F : const_level;
        g       = {4'b0, wa_reg[2]};
        case (mode)
            eap_pkg::CURVE_CUBIC: g = {4'b0, wa_reg[2]} << 2;
            eap_pkg::CURVE_QUART: g = {4'b0, wa_reg[2]} << 3;
            default:              g = {4'b0, wa_reg[2]} << 1;
        endcase
        if (g > ONE_PG) begin
            g = ONE_PG;
        end
        case (mode)
            eap_pkg::CURVE_QUAD, eap_pkg::CURVE_CUBIC, eap_pkg::CURVE_QUART: begin
                cur = (wu_reg[2] < HALF_P) ? g[P:0] : ONE_P - g[P:0];
            end
            eap_pkg::CURVE_CONST: cur = {c_clamp, 1'b0};
            default:              cur = wu_reg[2];
        endcase
        r       = winv_reg[2] ? ONE_P - cur : cur;
        p_round = (r + (P+1)'(1)) >> 1;
        p_next  = (p_round > {1'b0, ONE_F}) ? ONE_F : p_round[FRAC_BITS:0];
        if (wb_reg[2]) begin
            p_next = '0;
        end
        else if (we_reg[2]) begin
            p_next = ONE_F;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fv_reg <= 1'b0;
        end
        else if (en) begin
            fv_reg <= wv_reg[2];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            fp_reg <= p_next;
        end
    end

    // ---- interpolation: multiply, then round and add
    logic                    lv_reg;
    logic [FRAC_BITS:0]      lp_reg;
    logic signed [PRODW-1:0] lprod_reg;
    logic signed [LW:0]      diff;
    logic signed [PRODW-1:0] rounded;
    logic [LW-1:0]           lvl_next;

    assign diff = (LW+1)'(to_value) - (LW+1)'(from_value);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lv_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en) begin
            lv_reg    <= fv_reg;
            out_valid <= lv_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            lp_reg    <= fp_reg;
            lprod_reg <= PRODW'(diff) * PRODW'(signed'({1'b0, fp_reg}));
            progress  <= lp_reg;
            level     <= signed'(lvl_next);
        end
    end

    always_comb begin
        rounded  = (lprod_reg + (PRODW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        lvl_next = LW'(from_value) + rounded[LW-1:0];
    end

endmodule

// ===== rtl/eased_animation_progress.sv =====
// ----------------------------------------------------------------------------
// eased_animation_progress
// Eased Q1.FRAC_BITS progress and interpolated level for each time sample.
// ----------------------------------------------------------------------------
//  channel  | role   | payload
//  ---------+--------+----------------------------------------
//  sample   | sink   | now_ticks
//  result   | source | progress, level
//  cfg      | sink   | index, data (register writes, always ready)
//
//  One sample per cycle sustained while the result is not stalled; the wrap
//  and phase division pipelines each resolve one bit per stage.
//  Reset clears all valid flags and loads register defaults (duration 1).
//  A stalled result holds the whole pipeline; the front and the two-entry
//  queue keep taking samples until the queue fills.
// ----------------------------------------------------------------------------
module eased_animation_progress #(
    parameter int TIME_BITS = eap_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = eap_pkg::FRAC_BITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    eap_sample_if.sink    sample,
    eap_result_if.source  result,
    eap_cfg_if.sink       cfg
);

    localparam int LW = eap_pkg::LEVEL_W;

    logic [TIME_BITS-1:0]           start_reg;
    logic [TIME_BITS-1:0]           duration_reg;
    logic                           repeat_reg;
    logic [eap_pkg::MODE_W-1:0]     mode_reg;
    logic                           mirror_reg;
    logic [FRAC_BITS:0]             const_reg;
    logic signed [LW-1:0]           from_reg;
    logic signed [LW-1:0]           to_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_reg    <= '0;
            duration_reg <= TIME_BITS'(1);
            repeat_reg   <= 1'b0;
            mode_reg     <= eap_pkg::CURVE_LINEAR;
            mirror_reg   <= 1'b0;
            const_reg    <= '0;
            from_reg     <= '0;
            to_reg       <= '0;
        end
        else if (cfg.valid) begin
            unique case (eap_pkg::cfg_idx_t'(cfg.index))
                eap_pkg::REG_START:    start_reg    <= cfg.data[TIME_BITS-1:0];
                eap_pkg::REG_DURATION: duration_reg <= cfg.data[TIME_BITS-1:0];
                eap_pkg::REG_REPEAT:   repeat_reg   <= cfg.data[0];
                eap_pkg::REG_CURVE:    mode_reg     <= cfg.data[eap_pkg::MODE_W-1:0];
                eap_pkg::REG_MIRROR:   mirror_reg   <= cfg.data[0];
                eap_pkg::REG_CONST:    const_reg    <= cfg.data[FRAC_BITS:0];
                eap_pkg::REG_FROM:     from_reg     <= signed'(cfg.data[LW-1:0]);
                eap_pkg::REG_TO:       to_reg       <= signed'(cfg.data[LW-1:0]);
                default:               start_reg    <= start_reg;
            endcase
        end
    end

    logic                 push_valid;
    logic                 push_ready;
    logic [TIME_BITS:0]   push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [TIME_BITS:0]   pop_data;

    eap_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_ready   (sample.ready),
        .now_ticks  (sample.now_ticks),
        .start_time (start_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    eap_queue #(.W(TIME_BITS + 1)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    eap_back #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pop_valid),
        .in_ready    (pop_ready),
        .in_data     (pop_data),
        .duration    (duration_reg),
        .repeat_en   (repeat_reg),
        .mode        (mode_reg),
        .mirror_en   (mirror_reg),
        .const_level (const_reg),
        .from_value  (from_reg),
        .to_value    (to_reg),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .progress    (result.progress),
        .level       (result.level)
    );

endmodule

// ===== rtl/eap_checker.sv =====
// ----------------------------------------------------------------------------
// eap_props
// Port-level checks of the eased animation progress block.
// ----------------------------------------------------------------------------
module eap_props #(
    parameter int FRAC_BITS = eap_pkg::FRAC_BITS_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [FRAC_BITS:0]                 progress,
    input logic signed [eap_pkg::LEVEL_W-1:0] level
);

    localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // a clock edge seen in reset leaves no result pending
    a_idle_in_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> progress <= ONE_F)
        else $error("progress above one");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("register port not ready");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(progress) && $stable(level))
        else $error("stalled result changed");

endmodule

bind eased_animation_progress eap_props #(.FRAC_BITS(FRAC_BITS)) u_eap_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .progress  (result.progress),
    .level     (result.level)
);
